// ===== rtl/core/dad_pkg.sv =====
// Package for the DCC asymmetry detector: scaling constants, class codes,
// sequencer states and shared-multiplier operation codes.
// No dependencies; used by dad_mul_unit and dcc_asymmetry_detector.
`default_nettype none

package dad_pkg;

  // Default parameter values
  localparam int unsigned ADC_BITS_DEF   = 12;
  localparam int unsigned TRACK_BITS_DEF = 16;

  // Millivolt scaling: ((s * 3300) >> 12) * 176 / 10
  localparam int unsigned SCALE_MUL   = 3300;
  localparam int unsigned SCALE_SHIFT = 12;
  localparam int unsigned GAIN_MUL    = 176;
  // Reciprocal of 10 for a multiply and shift, exact for any 32-bit dividend
  localparam logic [31:0] RECIP_DIV10 = 32'hCCCC_CCCD;
  localparam int unsigned RECIP_SHIFT = 35;
  localparam int unsigned MUL_B_BITS  = 32;
  // Headroom above ADC_BITS: after the gain multiply, and in the final value
  localparam int unsigned GAIN_HEADROOM = 8;
  localparam int unsigned MV_HEADROOM   = 4;

  // Output limits
  localparam int unsigned ASYM_LIMIT = 65535;
  localparam int unsigned ASYM_BITS  = 17;

  // Register file
  localparam int unsigned THRESH_BITS  = 16;
  localparam logic [15:0] RED_RESET    = 16'd3000;
  localparam logic [15:0] ORANGE_RESET = 16'd340;
  localparam logic        REG_RED      = 1'b0;
  localparam logic        REG_ORANGE   = 1'b1;

  // Level history entry code for an empty slot
  localparam logic [1:0] NO_LEVEL = 2'd2;

  typedef enum logic [1:0] {
    CLASS_GREEN  = 2'd0,
    CLASS_ORANGE = 2'd1,
    CLASS_RED    = 2'd2
  } class_e;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_SCALE,
    OP_GAIN,
    OP_RECIP
  } mul_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_GAIN,
    ST_MUL_RECIP,
    ST_STEP,
    ST_EMIT
  } state_e;

endpackage

`default_nettype wire

// ===== rtl/core/dad_mul_unit.sv =====
// Shared multiplier of the DCC asymmetry detector with its product register.
// Three passes turn a raw ADC code into millivolts. Depends on dad_pkg.
`default_nettype none

module dad_mul_unit #(
  parameter int unsigned ADC_BITS = dad_pkg::ADC_BITS_DEF
) (
  input  wire logic                                   clk_i,
  input  wire dad_pkg::mul_op_e                       op_i,
  input  wire logic [ADC_BITS-1:0]                    raw_i,
  output logic      [ADC_BITS+dad_pkg::MV_HEADROOM-1:0] mv_o
);

  localparam int unsigned AW = ADC_BITS + dad_pkg::GAIN_HEADROOM;
  localparam int unsigned BW = dad_pkg::MUL_B_BITS;
  localparam int unsigned PW = AW + BW;
  localparam int unsigned MW = ADC_BITS + dad_pkg::MV_HEADROOM;

  logic [AW-1:0] mul_a;
  logic [BW-1:0] mul_b;
  logic [PW-1:0] prod_d, prod_q;

  always_comb begin
    unique case (op_i)
      dad_pkg::OP_SCALE: begin
        mul_a = AW'(raw_i);
        mul_b = BW'(dad_pkg::SCALE_MUL);
      end
      dad_pkg::OP_GAIN: begin
        // truncating divide by 4096
        mul_a = AW'(prod_q[dad_pkg::SCALE_SHIFT +: ADC_BITS]);
        mul_b = BW'(dad_pkg::GAIN_MUL);
      end
      dad_pkg::OP_RECIP: begin
        mul_a = prod_q[AW-1:0];
        mul_b = dad_pkg::RECIP_DIV10;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod_d = PW'(mul_a) * PW'(mul_b);
  end

  always_ff @(posedge clk_i) begin
    if (op_i != dad_pkg::OP_HOLD) begin
      prod_q <= prod_d;
    end
  end

  assign mv_o = prod_q[dad_pkg::RECIP_SHIFT +: MW];

endmodule

`default_nettype wire

// ===== rtl/core/dcc_asymmetry_detector.sv =====
// DCC asymmetry detector top level: handshakes, APB registers, sequencer,
// level trackers and classification. Depends on dad_pkg and dad_mul_unit.
`default_nettype none

// Channel   Handshake                 Payload
// input     in_valid_i / in_stall_o   dcc_level_i, adc_sample_i
// output    out_valid_o / out_stall_i asym_mv_o, signal_class_o, light_on_o
// config    APB psel/penable/pwrite   paddr, pwdata, prdata, pready
//
// Each transaction takes three passes through the shared multiplier
// (scale, gain, divide by 10), one tracker step and one result stage.
// Input is stalled from acceptance until the result is loaded into the
// output register; a stalled output holds the sequencer in the result stage.
// Reset restores thresholds, clears trackers, light and history; no pass.

module dcc_asymmetry_detector #(
  parameter int unsigned ADC_BITS   = dad_pkg::ADC_BITS_DEF,
  parameter int unsigned TRACK_BITS = dad_pkg::TRACK_BITS_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // input channel
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic                dcc_level_i,
  input  wire logic [ADC_BITS-1:0] adc_sample_i,
  // output channel
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic signed [16:0]       asym_mv_o,
  output logic [1:0]               signal_class_o,
  output logic                     light_on_o,
  // configuration
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [2:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  localparam int unsigned MW   = ADC_BITS + dad_pkg::MV_HEADROOM;
  localparam int unsigned CW   = (MW > TRACK_BITS) ? MW : TRACK_BITS;
  localparam int unsigned DW   = TRACK_BITS + 2;
  localparam int unsigned TH   = dad_pkg::THRESH_BITS;
  localparam int unsigned AB   = dad_pkg::ASYM_BITS;
  localparam logic [TRACK_BITS-1:0] TrackMax = {TRACK_BITS{1'b1}};
  localparam logic signed [DW-1:0]  AsymMax  = DW'(dad_pkg::ASYM_LIMIT);
  localparam logic signed [DW-1:0]  AsymMin  = -AsymMax;

  // registers
  logic [TH-1:0] red_q, orange_q;
  logic          cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      red_q    <= dad_pkg::RED_RESET;
      orange_q <= dad_pkg::ORANGE_RESET;
    end else if (cfg_we) begin
      unique case (paddr[2])
        dad_pkg::REG_RED:    red_q    <= pwdata[TH-1:0];
        dad_pkg::REG_ORANGE: orange_q <= pwdata[TH-1:0];
        default:             red_q    <= red_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      dad_pkg::REG_RED:    prdata = 32'(red_q);
      dad_pkg::REG_ORANGE: prdata = 32'(orange_q);
      default:             prdata = '0;
    endcase
  end

  // sequencer
  dad_pkg::state_e  state_d, state_q;
  dad_pkg::mul_op_e mul_op;
  logic             in_accept, step_en, emit_en, out_free;

  assign in_accept = in_valid_i & ~in_stall_o;
  assign out_free  = ~out_valid_o | ~out_stall_i;

  always_comb begin
    unique case (state_q)
      dad_pkg::ST_IDLE:      state_d = in_valid_i ? dad_pkg::ST_MUL_GAIN : dad_pkg::ST_IDLE;
      dad_pkg::ST_MUL_GAIN:  state_d = dad_pkg::ST_MUL_RECIP;
      dad_pkg::ST_MUL_RECIP: state_d = dad_pkg::ST_STEP;
      dad_pkg::ST_STEP:      state_d = dad_pkg::ST_EMIT;
      dad_pkg::ST_EMIT:      state_d = out_free ? dad_pkg::ST_IDLE : dad_pkg::ST_EMIT;
      default:               state_d = dad_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = 1'b1;
    mul_op     = dad_pkg::OP_HOLD;
    step_en    = 1'b0;
    emit_en    = 1'b0;
    unique case (state_q)
      dad_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        // first pass runs straight off the input port
        if (in_valid_i) begin
          mul_op = dad_pkg::OP_SCALE;
        end
      end
      dad_pkg::ST_MUL_GAIN:  mul_op  = dad_pkg::OP_GAIN;
      dad_pkg::ST_MUL_RECIP: mul_op  = dad_pkg::OP_RECIP;
      dad_pkg::ST_STEP:      step_en = 1'b1;
      dad_pkg::ST_EMIT:      emit_en = out_free;
      default:               in_stall_o = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dad_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // scaling
  logic [MW-1:0] mv;

  dad_mul_unit #(
    .ADC_BITS(ADC_BITS)
  ) u_mul (
    .clk_i (clk_i),
    .op_i  (mul_op),
    .raw_i (adc_sample_i),
    .mv_o  (mv)
  );

  // tracker step
  logic                  level_q;
  logic [1:0]            hist_q [3];
  logic [TRACK_BITS-1:0] trk1_q, trk0_q;
  logic [TRACK_BITS-1:0] trk_cur, trk_next;
  logic                  take;

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      level_q <= dcc_level_i;
    end
  end

  assign take    = ({1'b0, level_q} == hist_q[1]) && (hist_q[1] != hist_q[2]);
  assign trk_cur = level_q ? trk1_q : trk0_q;

  always_comb begin
    if (CW'(mv) > CW'(trk_cur)) begin
      trk_next = (trk_cur == TrackMax) ? trk_cur : trk_cur + TRACK_BITS'(1);
    end else begin
      trk_next = (trk_cur == '0) ? trk_cur : trk_cur - TRACK_BITS'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q[0] <= dad_pkg::NO_LEVEL;
      hist_q[1] <= dad_pkg::NO_LEVEL;
      hist_q[2] <= dad_pkg::NO_LEVEL;
      trk1_q    <= '0;
      trk0_q    <= '0;
    end else if (step_en) begin
      hist_q[2] <= hist_q[1];
      hist_q[1] <= hist_q[0];
      hist_q[0] <= {1'b0, level_q};
      if (take) begin
        if (level_q) begin
          trk1_q <= trk_next;
        end else begin
          trk0_q <= trk_next;
        end
      end
    end
  end

  // classification and result register
  logic signed [DW-1:0] diff, red_s, orange_s;
  logic                 light_q, light_d;
  dad_pkg::class_e      cls;
  logic signed [AB-1:0] asym_sat;
  logic                 out_valid_q;

  assign diff     = signed'(DW'(trk1_q)) - signed'(DW'(trk0_q));
  assign red_s    = signed'(DW'(red_q));
  assign orange_s = signed'(DW'(orange_q));

  always_comb begin
    priority if (diff > red_s) begin
      cls     = dad_pkg::CLASS_RED;
      light_d = light_q;
    end else if (diff > orange_s) begin
      cls     = dad_pkg::CLASS_ORANGE;
      light_d = 1'b1;
    end else begin
      cls     = dad_pkg::CLASS_GREEN;
      light_d = 1'b0;
    end
    priority if (diff > AsymMax) begin
      asym_sat = AB'(AsymMax);
    end else if (diff < AsymMin) begin
      asym_sat = AB'(AsymMin);
    end else begin
      asym_sat = AB'(diff);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      light_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (emit_en) begin
        light_q     <= light_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        // drop the transaction once taken
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_en) begin
      asym_mv_o      <= asym_sat;
      signal_class_o <= cls;
      light_on_o     <= light_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== tb/sv/dcc_asymmetry_detector_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for dcc_asymmetry_detector: a directed table, then random
// polarity/sample streams under several threshold settings, checked against a local tracker.
// Depends on dad_pkg and the detector RTL.

module dcc_asymmetry_detector_test;

  localparam int SAMPLE_BITS   = dad_pkg::ADC_BITS_DEF;
  localparam int RESET_CYCLES  = 7;
  localparam int MAX_WAIT      = 9;
  localparam int IDLE_LIMIT    = 400;
  localparam int DRAIN_HOLD    = 8;
  localparam int SETTLE_CYCLES = 20;
  localparam int RANDOM_PHASES = 11;
  localparam int PHASE_ITEMS   = 100;
  localparam int DIR_ROWS      = 20;
  localparam int MAX_REPORTS   = 10;
  localparam int unsigned MV_DIV    = 10;
  localparam int unsigned TRACK_MAX = 65535;
  localparam logic [2:0] ADDR_RED    = {dad_pkg::REG_RED, 2'b00};
  localparam logic [2:0] ADDR_ORANGE = {dad_pkg::REG_ORANGE, 2'b00};

  typedef struct packed {
    logic signed [16:0] asym;
    dad_pkg::class_e    cls;
    logic               light;
  } reading_t;

  typedef struct {
    logic                   lvl;
    logic [SAMPLE_BITS-1:0] smp;
    logic                   typed;
    reading_t               want;
  } stim_row_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   in_valid_i;
  logic                   in_stall_o;
  logic                   dcc_level_i;
  logic [SAMPLE_BITS-1:0] adc_sample_i;
  logic                   out_valid_o;
  logic                   out_stall_i;
  logic signed [16:0]     asym_mv_o;
  logic [1:0]             signal_class_o;
  logic                   light_on_o;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [2:0]             paddr;
  logic [31:0]            pwdata;
  logic [31:0]            prdata;
  logic                   pready;

  // Local copy of the detector state and thresholds
  logic [1:0]  level_hist [0:2];
  int unsigned track_one;
  int unsigned track_zero;
  logic        light_q;
  logic [15:0] red_mv;
  logic [15:0] orange_mv;

  reading_t  readings_due [$];
  stim_row_t dir_rows [0:DIR_ROWS-1];
  int        mismatches = 0;
  int        idle_cycles = 0;
  bit        calm = 1'b0;

  dcc_asymmetry_detector DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .dcc_level_i    (dcc_level_i),
    .adc_sample_i   (adc_sample_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .asym_mv_o      (asym_mv_o),
    .signal_class_o (signal_class_o),
    .light_on_o     (light_on_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #2 clk_i = ~clk_i;

  function automatic int unsigned step_tracker(int unsigned trk, int unsigned mv);
    if (mv > trk) begin
      return (trk < TRACK_MAX) ? trk + 1 : trk;
    end
    // equal also steps down
    return (trk > 0) ? trk - 1 : trk;
  endfunction

  task automatic track_and_classify(input logic lvl, input logic [SAMPLE_BITS-1:0] smp,
                                    output reading_t r);
    int unsigned raw;
    int unsigned mv;
    int          diff;
    int          shown;
    raw = smp;
    mv = (((raw * dad_pkg::SCALE_MUL) >> dad_pkg::SCALE_SHIFT) * dad_pkg::GAIN_MUL) / MV_DIV;
    if ({1'b0, lvl} == level_hist[1] && level_hist[1] != level_hist[2]) begin
      if (lvl) begin
        track_one = step_tracker(track_one, mv);
      end else begin
        track_zero = step_tracker(track_zero, mv);
      end
    end
    level_hist[2] = level_hist[1];
    level_hist[1] = level_hist[0];
    level_hist[0] = {1'b0, lvl};
    diff = int'(track_one) - int'(track_zero);
    if (diff > int'(red_mv)) begin
      r.cls = dad_pkg::CLASS_RED;
    end else if (diff > int'(orange_mv)) begin
      r.cls = dad_pkg::CLASS_ORANGE;
      light_q = 1'b1;
    end else begin
      r.cls = dad_pkg::CLASS_GREEN;
      light_q = 1'b0;
    end
    shown = diff;
    if (shown > int'(dad_pkg::ASYM_LIMIT)) shown = dad_pkg::ASYM_LIMIT;
    if (shown < -int'(dad_pkg::ASYM_LIMIT)) shown = -int'(dad_pkg::ASYM_LIMIT);
    r.asym  = shown[16:0];
    r.light = light_q;
  endtask

  function automatic stim_row_t mk_row(logic lvl, logic [SAMPLE_BITS-1:0] smp, logic typed,
                                       logic signed [16:0] asym, dad_pkg::class_e cls,
                                       logic light);
    stim_row_t row;
    row.lvl        = lvl;
    row.smp        = smp;
    row.typed      = typed;
    row.want.asym  = asym;
    row.want.cls   = cls;
    row.want.light = light;
    return row;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  // Hold payload until accepted, then fold the sample into the local tracker
  task automatic send_sample(input logic lvl, input logic [SAMPLE_BITS-1:0] smp, input int gap,
                             input logic typed, input reading_t want);
    reading_t r;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    dcc_level_i  <= lvl;
    adc_sample_i <= smp;
    do @(posedge clk_i); while (in_stall_o);
    track_and_classify(lvl, smp, r);
    readings_due.push_back(typed ? want : r);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (readings_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_HOLD) @(posedge clk_i);
  endtask

  task automatic reg_write(input logic [2:0] addr, input logic [15:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    // upper bits are don't-care for the 16-bit thresholds
    pwdata  <= {16'($urandom), val};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (addr == ADDR_RED) begin
      red_mv = val;
    end else begin
      orange_mv = val;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic reg_check(input logic [2:0] addr, input logic [15:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== {16'h0, val}) begin
      report_mismatch($sformatf("register %0d read expected %h got %h", addr, val, prdata));
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_thresholds(input int phase);
    logic [15:0] red_val;
    logic [15:0] orange_val;
    case (phase)
      0: begin
        red_val    = 16'hFFFF;
        orange_val = 16'hFFFF;
      end
      1: begin
        red_val    = 16'h0;
        orange_val = 16'h0;
      end
      2: begin
        red_val    = 16'h0;
        orange_val = 16'hFFFF;
      end
      3: begin
        red_val    = 16'hFFFF;
        orange_val = 16'h0;
      end
      default: begin
        red_val    = 16'($urandom_range(0, 150));
        orange_val = 16'($urandom_range(0, 150));
      end
    endcase
    reg_write(ADDR_RED, red_val);
    reg_write(ADDR_ORANGE, orange_val);
    reg_check(ADDR_RED, red_val);
    reg_check(ADDR_ORANGE, orange_val);
  endtask

  // Result side: random stall per transaction (none in calm phases), compare against the oldest pending reading
  initial begin : result_sink
    int       hold;
    reading_t want;
    wait (rst_ni === 1'b1);
    forever begin
      hold = calm ? 0 : $urandom_range(0, MAX_WAIT);
      repeat (hold) begin
        @(negedge clk_i);
        out_stall_i <= 1'b1;
      end
      @(negedge clk_i);
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
      if (readings_due.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: asym %0d class %0d light %0b",
                                  asym_mv_o, signal_class_o, light_on_o));
      end else begin
        want = readings_due.pop_front();
        if (asym_mv_o !== want.asym || signal_class_o !== want.cls ||
            light_on_o !== want.light) begin
          report_mismatch($sformatf("asym %0d/%0d class %0d/%0d light %0b/%0b (want/got)",
                                    want.asym, asym_mv_o, want.cls, signal_class_o,
                                    want.light, light_on_o));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || (psel && penable)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic                   lvl;
    logic                   prev_lvl;
    logic                   hi_level;
    logic [SAMPLE_BITS-1:0] smp;
    int                     pick;
    reading_t               none;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    dcc_level_i  = 1'b0;
    adc_sample_i = '0;
    out_stall_i  = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    none         = '{asym: '0, cls: dad_pkg::CLASS_GREEN, light: 1'b0};
    level_hist[0] = dad_pkg::NO_LEVEL;
    level_hist[1] = dad_pkg::NO_LEVEL;
    level_hist[2] = dad_pkg::NO_LEVEL;
    track_one  = 0;
    track_zero = 0;
    light_q    = 1'b0;
    red_mv     = dad_pkg::RED_RESET;
    orange_mv  = dad_pkg::ORANGE_RESET;

    // Empty history, low saturation on an equal sample, step down, negative difference
    dir_rows[0]  = mk_row(1'b1, 12'hFFF, 1'b1, 17'sd0, dad_pkg::CLASS_GREEN, 1'b0);
    dir_rows[1]  = mk_row(1'b0, 12'h000, 1'b1, 17'sd0, dad_pkg::CLASS_GREEN, 1'b0);
    dir_rows[2]  = mk_row(1'b1, 12'hFFF, 1'b1, 17'sd1, dad_pkg::CLASS_GREEN, 1'b0);
    dir_rows[3]  = mk_row(1'b0, 12'h000, 1'b1, 17'sd1, dad_pkg::CLASS_GREEN, 1'b0);
    dir_rows[4]  = mk_row(1'b1, 12'h000, 1'b1, 17'sd0, dad_pkg::CLASS_GREEN, 1'b0);
    dir_rows[5]  = mk_row(1'b0, 12'hFFF, 1'b1, -17'sd1, dad_pkg::CLASS_GREEN, 1'b0);
    dir_rows[6]  = mk_row(1'b0, 12'hFFF, 1'b1, -17'sd1, dad_pkg::CLASS_GREEN, 1'b0);
    dir_rows[7]  = mk_row(1'b1, 12'hFFF, 1'b0, '0, dad_pkg::CLASS_GREEN, 1'b0);
    dir_rows[8]  = mk_row(1'b1, 12'hFFF, 1'b0, '0, dad_pkg::CLASS_GREEN, 1'b0);
    dir_rows[9]  = mk_row(1'b0, 12'h000, 1'b0, '0, dad_pkg::CLASS_GREEN, 1'b0);
    dir_rows[10] = mk_row(1'b0, 12'h000, 1'b0, '0, dad_pkg::CLASS_GREEN, 1'b0);
    dir_rows[11] = mk_row(1'b1, 12'd2048, 1'b0, '0, dad_pkg::CLASS_GREEN, 1'b0);
    dir_rows[12] = mk_row(1'b0, 12'd2, 1'b0, '0, dad_pkg::CLASS_GREEN, 1'b0);
    dir_rows[13] = mk_row(1'b1, 12'd1, 1'b0, '0, dad_pkg::CLASS_GREEN, 1'b0);
    dir_rows[14] = mk_row(1'b0, 12'd4094, 1'b0, '0, dad_pkg::CLASS_GREEN, 1'b0);
    dir_rows[15] = mk_row(1'b1, 12'hFFF, 1'b0, '0, dad_pkg::CLASS_GREEN, 1'b0);
    dir_rows[16] = mk_row(1'b0, 12'h000, 1'b0, '0, dad_pkg::CLASS_GREEN, 1'b0);
    dir_rows[17] = mk_row(1'b1, 12'hAAA, 1'b0, '0, dad_pkg::CLASS_GREEN, 1'b0);
    dir_rows[18] = mk_row(1'b0, 12'h555, 1'b0, '0, dad_pkg::CLASS_GREEN, 1'b0);
    dir_rows[19] = mk_row(1'b1, 12'd3000, 1'b0, '0, dad_pkg::CLASS_GREEN, 1'b0);

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    reg_check(ADDR_RED, dad_pkg::RED_RESET);
    reg_check(ADDR_ORANGE, dad_pkg::ORANGE_RESET);

    for (int i = 0; i < DIR_ROWS; i++) begin
      send_sample(dir_rows[i].lvl, dir_rows[i].smp, $urandom_range(0, MAX_WAIT),
                  dir_rows[i].typed, dir_rows[i].want);
    end
    wait_drained();

    prev_lvl = 1'b0;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      set_thresholds(phase);
      calm     = (phase == 4 || phase == 8);
      hi_level = 1'($urandom_range(0, 1));
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // mostly alternating polarity so every sample is taken; the rest is noise
        if ($urandom_range(0, 99) < 85) begin
          lvl = ~prev_lvl;
        end else begin
          lvl = 1'($urandom_range(0, 1));
        end
        pick = $urandom_range(0, 9);
        if (pick < 2) begin
          smp = SAMPLE_BITS'($urandom_range(0, 4095));
        end else if (lvl == hi_level) begin
          smp = SAMPLE_BITS'($urandom_range(2048, 4095));
        end else begin
          smp = SAMPLE_BITS'($urandom_range(0, 1024));
        end
        send_sample(lvl, smp, calm ? 0 : $urandom_range(0, MAX_WAIT), 1'b0, none);
        prev_lvl = lvl;
      end
      wait_drained();
    end

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
